/* rtl/core/rdcd_pkg.sv */
// ----------------------------------------------------------------------------
// rdcd_pkg: shared types and constants of the remote drive command decoder
// Transaction structs, event codes, command characters and control bit masks.
// ----------------------------------------------------------------------------
package rdcd_pkg;

  // input transaction: command byte or millisecond tick
  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } rdcd_in_t;

  // result transaction
  typedef struct packed {
    logic [15:0] control_word;
    logic [6:0]  speed_percent;
    logic [2:0]  event_res;
  } rdcd_out_t;

  // event codes reported with every result
  typedef enum logic [2:0] {
    EV_APPLIED   = 3'd0,
    EV_REPEAT    = 3'd1,
    EV_UNKNOWN   = 3'd2,
    EV_ERR_CLEAR = 3'd3,
    EV_TIMEOUT   = 3'd4,
    EV_TICK      = 3'd5
  } rdcd_evt_t;

  // item kinds
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam int unsigned SILENCE_W = 17;
  localparam logic [SILENCE_W-1:0] SILENCE_MAX = '1;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [1:0]  ERR_LIMIT     = 2'd3;
  localparam logic [6:0]  SPEED_MAX     = 7'd100;

  // control word masks
  localparam logic [15:0] LINK_BITS  = 16'hC000;
  localparam logic [15:0] DIR_MASK   = 16'h000F;
  localparam logic [15:0] HORN_BITS  = 16'h0010;
  localparam logic [15:0] LIGHT_BITS = 16'h2020;
  localparam logic [15:0] REAR_BITS  = 16'h0040;
  localparam logic [15:0] HAZ_BITS   = 16'h1080;

  // direction patterns on bits 3..0
  localparam logic [3:0] DIR_STOP  = 4'h0;
  localparam logic [3:0] DIR_FWD   = 4'h1;
  localparam logic [3:0] DIR_LEFT  = 4'h2;
  localparam logic [3:0] DIR_BACK  = 4'h4;
  localparam logic [3:0] DIR_RIGHT = 4'h8;
  localparam logic [3:0] DIR_FL    = 4'h3;
  localparam logic [3:0] DIR_FR    = 4'h9;
  localparam logic [3:0] DIR_BL    = 4'h6;
  localparam logic [3:0] DIR_BR    = 4'hC;

  // command characters
  localparam logic [7:0] CH_T  = 8'h54;
  localparam logic [7:0] CH_D  = 8'h44;
  localparam logic [7:0] CH_S  = 8'h53;
  localparam logic [7:0] CH_F  = 8'h46;
  localparam logic [7:0] CH_L  = 8'h4C;
  localparam logic [7:0] CH_B  = 8'h42;
  localparam logic [7:0] CH_R  = 8'h52;
  localparam logic [7:0] CH_G  = 8'h47;
  localparam logic [7:0] CH_I  = 8'h49;
  localparam logic [7:0] CH_H  = 8'h48;
  localparam logic [7:0] CH_J  = 8'h4A;
  localparam logic [7:0] CH_VU = 8'h56;
  localparam logic [7:0] CH_VL = 8'h76;
  localparam logic [7:0] CH_WU = 8'h57;
  localparam logic [7:0] CH_WL = 8'h77;
  localparam logic [7:0] CH_UU = 8'h55;
  localparam logic [7:0] CH_UL = 8'h75;
  localparam logic [7:0] CH_XU = 8'h58;
  localparam logic [7:0] CH_XL = 8'h78;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_1  = 8'h31;
  localparam logic [7:0] CH_2  = 8'h32;
  localparam logic [7:0] CH_3  = 8'h33;
  localparam logic [7:0] CH_4  = 8'h34;
  localparam logic [7:0] CH_5  = 8'h35;
  localparam logic [7:0] CH_6  = 8'h36;
  localparam logic [7:0] CH_7  = 8'h37;
  localparam logic [7:0] CH_8  = 8'h38;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_Q  = 8'h71;

endpackage

/* rtl/core/remote_drive_command_decoder.sv */
// ----------------------------------------------------------------------------
// remote_drive_command_decoder: single-character drive command decoder
// Turns command bytes and millisecond ticks into a drive control word,
// a speed percentage and an event code, one result per transaction.
// ----------------------------------------------------------------------------
// result: registered on input acceptance, in the result or the skid register
// throughput: one transaction per cycle while in_stall is low; a two-entry output
//   stage (result register plus skid register) keeps input acceptance going while
//   out_stall holds one result
// reset: synchronous rst clears all decoder state, sets timeout_ms to 1000
//   and empties the output stage
module remote_drive_command_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  rdcd_pkg::rdcd_in_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rdcd_pkg::rdcd_out_t out_data
);
  import rdcd_pkg::*;

  // decoder state
  logic [15:0]          timeout_ms;
  logic [7:0]           last_code;
  logic [15:0]          drive_word;
  logic [6:0]           speed_level;
  logic [1:0]           error_count;
  logic [SILENCE_W-1:0] silence_count;

  logic [7:0]           last_code_next;
  logic [15:0]          drive_word_next;
  logic [6:0]           speed_level_next;
  logic [1:0]           error_count_next;
  logic [SILENCE_W-1:0] silence_count_next;
  rdcd_evt_t            evt_next;

  // decode scratch
  logic [15:0]          cmd_word;
  logic [6:0]           cmd_speed;
  logic                 cmd_known;
  logic                 cmd_clear;
  logic [SILENCE_W-1:0] silence_inc;

  // output stage
  logic      skid_valid;
  rdcd_out_t skid_data;
  rdcd_out_t result;
  logic      in_accept;

  assign in_stall  = skid_valid;
  assign in_accept = in_valid & ~skid_valid;

  // character decode on top of the word with link bits set
  always_comb begin
    cmd_word  = drive_word | LINK_BITS;
    cmd_speed = speed_level;
    cmd_known = 1'b1;
    cmd_clear = 1'b0;
    unique case (in_data.rx_byte)
      CH_T, CH_D: cmd_clear = 1'b1;
      CH_S:  cmd_word[3:0] = DIR_STOP;
      CH_F:  cmd_word[3:0] = DIR_FWD;
      CH_L:  cmd_word[3:0] = DIR_LEFT;
      CH_B:  cmd_word[3:0] = DIR_BACK;
      CH_R:  cmd_word[3:0] = DIR_RIGHT;
      CH_G:  cmd_word[3:0] = DIR_FL;
      CH_I:  cmd_word[3:0] = DIR_FR;
      CH_H:  cmd_word[3:0] = DIR_BL;
      CH_J:  cmd_word[3:0] = DIR_BR;
      CH_VU: cmd_word = cmd_word | HORN_BITS;
      CH_VL: cmd_word = cmd_word & ~HORN_BITS;
      CH_WU: cmd_word = cmd_word | LIGHT_BITS;
      CH_WL: cmd_word = cmd_word & ~LIGHT_BITS;
      CH_UU: cmd_word = cmd_word | REAR_BITS;
      CH_UL: cmd_word = cmd_word & ~REAR_BITS;
      CH_XU: cmd_word = cmd_word | HAZ_BITS;
      CH_XL: cmd_word = cmd_word & ~HAZ_BITS;
      CH_0:  cmd_speed = 7'd0;
      CH_1:  cmd_speed = 7'd20;
      CH_2:  cmd_speed = 7'd30;
      CH_3:  cmd_speed = 7'd40;
      CH_4:  cmd_speed = 7'd50;
      CH_5:  cmd_speed = 7'd60;
      CH_6:  cmd_speed = 7'd70;
      CH_7:  cmd_speed = 7'd80;
      CH_8:  cmd_speed = 7'd90;
      CH_9, CH_Q: cmd_speed = SPEED_MAX;
      default: cmd_known = 1'b0;
    endcase
  end

  // saturating silence increment
  assign silence_inc = (silence_count == SILENCE_MAX) ? silence_count
                                                      : silence_count + 1'b1;

  // next state for one transaction
  always_comb begin
    last_code_next     = last_code;
    drive_word_next    = drive_word;
    speed_level_next   = speed_level;
    error_count_next   = error_count;
    silence_count_next = silence_count;
    evt_next           = EV_TICK;
    if (in_data.func == FUNC_BYTE) begin
      silence_count_next = '0;
      if (in_data.rx_byte == last_code) begin
        evt_next = EV_REPEAT;
      end else if (cmd_known) begin
        evt_next         = EV_APPLIED;
        error_count_next = '0;
        if (cmd_clear) begin
          last_code_next   = '0;
          drive_word_next  = '0;
          speed_level_next = '0;
        end else begin
          last_code_next   = in_data.rx_byte;
          drive_word_next  = cmd_word;
          speed_level_next = cmd_speed;
        end
      end else if (error_count == ERR_LIMIT) begin
        // fourth unknown in a row
        evt_next         = EV_ERR_CLEAR;
        error_count_next = '0;
        last_code_next   = '0;
        drive_word_next  = '0;
        speed_level_next = '0;
      end else begin
        evt_next         = EV_UNKNOWN;
        error_count_next = error_count + 1'b1;
        last_code_next   = in_data.rx_byte;
        drive_word_next  = drive_word | LINK_BITS;
      end
    end else if (silence_inc > {1'b0, timeout_ms}) begin
      // silence timeout clears the drive state like a T or D command
      evt_next           = EV_TIMEOUT;
      silence_count_next = '0;
      error_count_next   = '0;
      last_code_next     = '0;
      drive_word_next    = '0;
      speed_level_next   = '0;
    end else begin
      silence_count_next = silence_inc;
    end
  end

  assign result.control_word  = drive_word_next;
  assign result.speed_percent = speed_level_next;
  assign result.event_res     = evt_next;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_ms <= cfg_wr_data;
    end
  end

  // decoder state update
  always_ff @(posedge clk) begin
    if (rst) begin
      last_code     <= '0;
      drive_word    <= '0;
      speed_level   <= '0;
      error_count   <= '0;
      silence_count <= '0;
    end else if (in_accept) begin
      last_code     <= last_code_next;
      drive_word    <= drive_word_next;
      speed_level   <= speed_level_next;
      error_count   <= error_count_next;
      silence_count <= silence_count_next;
    end
  end

  // result register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_stall) begin
        skid_valid <= 1'b0;
      end
    end else if (in_accept) begin
      if (out_valid && out_stall) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // payload moves without reset
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!out_stall) begin
        out_data <= skid_data;
      end
    end else if (in_accept) begin
      if (out_valid && out_stall) begin
        skid_data <= result;
      end else begin
        out_data <= result;
      end
    end
  end

endmodule

/* rtl/core/rdcd_checker.sv */
// ----------------------------------------------------------------------------
// rdcd_checker: port-level checks of the remote drive command decoder
// Watches the result channel for handshake and control word consistency.
// ----------------------------------------------------------------------------
module rdcd_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input rdcd_pkg::rdcd_out_t out_data
);
  import rdcd_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // clearing events leave an empty word and zero speed
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.event_res == EV_TIMEOUT ||
                  out_data.event_res == EV_ERR_CLEAR)
    |-> out_data.control_word == '0 && out_data.speed_percent == '0)
    else $error("clear event with non-zero drive state");

  // an unknown code still raises the link bits
  a_link_bits: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.event_res == EV_UNKNOWN
    |-> out_data.control_word[15:14] == 2'b11)
    else $error("unknown code without link bits");

  // unused bits stay low and speed stays in range
  a_word_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.control_word[11:8] == '0 &&
                  out_data.speed_percent <= SPEED_MAX &&
                  out_data.event_res <= EV_TICK)
    else $error("result field out of range");

endmodule

bind remote_drive_command_decoder rdcd_checker u_rdcd_checker (.*);

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for remote_drive_command_decoder
// Command bytes and millisecond ticks are pushed through the valid/stall input
// with random gaps. A bit-level model of the decoder predicts every result,
// and the monitor compares each returned transaction field by field. Several
// timeout settings are applied between phases, the zero and full-scale values
// among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import rdcd_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  rdcd_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  rdcd_out_t   out_data;

  remote_drive_command_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // commands waiting to be sent and results still owed by the decoder
  rdcd_in_t  command_backlog [$];
  rdcd_out_t predicted_reports [$];
  logic [7:0] command_set [0:29];

  // handshake bookkeeping
  logic        item_taken = 1'b0;
  logic        result_taken = 1'b0;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  bit          sender_calm = 1'b0;
  bit          receiver_calm = 1'b0;

  // statistics
  int unsigned fail_count = 0;
  int unsigned items_in = 0;
  int unsigned reports_checked = 0;
  int unsigned timeout_clears = 0;
  int unsigned error_clears = 0;
  int unsigned repeats_seen = 0;

  // predictor state
  logic [15:0]          timeout_limit;
  logic [7:0]           prev_code;
  logic [15:0]          ctrl_word;
  logic [6:0]           speed_pct;
  logic [1:0]           unknown_run;
  logic [SILENCE_W-1:0] quiet_ms;

  rdcd_out_t want_report;

  function automatic int unsigned draw_wait(bit calm);
    if (calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 11);
  endfunction

  function automatic void clear_drive();
    ctrl_word = '0;
    speed_pct = '0;
    prev_code = '0;
  endfunction

  // decode one new code character, returns the event
  function automatic rdcd_evt_t apply_code(logic [7:0] code);
    logic known;
    known = 1'b1;
    ctrl_word = ctrl_word | LINK_BITS;
    case (code)
      CH_T, CH_D: clear_drive();
      CH_S: ctrl_word = {ctrl_word[15:4], DIR_STOP};
      CH_F: ctrl_word = {ctrl_word[15:4], DIR_FWD};
      CH_L: ctrl_word = {ctrl_word[15:4], DIR_LEFT};
      CH_B: ctrl_word = {ctrl_word[15:4], DIR_BACK};
      CH_R: ctrl_word = {ctrl_word[15:4], DIR_RIGHT};
      CH_G: ctrl_word = {ctrl_word[15:4], DIR_FL};
      CH_I: ctrl_word = {ctrl_word[15:4], DIR_FR};
      CH_H: ctrl_word = {ctrl_word[15:4], DIR_BL};
      CH_J: ctrl_word = {ctrl_word[15:4], DIR_BR};
      CH_VU: ctrl_word = ctrl_word | HORN_BITS;
      CH_VL: ctrl_word = ctrl_word & ~HORN_BITS;
      CH_WU: ctrl_word = ctrl_word | LIGHT_BITS;
      CH_WL: ctrl_word = ctrl_word & ~LIGHT_BITS;
      CH_UU: ctrl_word = ctrl_word | REAR_BITS;
      CH_UL: ctrl_word = ctrl_word & ~REAR_BITS;
      CH_XU: ctrl_word = ctrl_word | HAZ_BITS;
      CH_XL: ctrl_word = ctrl_word & ~HAZ_BITS;
      CH_0: speed_pct = '0;
      CH_1, CH_2, CH_3, CH_4, CH_5, CH_6, CH_7, CH_8:
        speed_pct = 7'((code - CH_0) * 8'd10 + 8'd10);
      CH_9, CH_Q: speed_pct = SPEED_MAX;
      default: known = 1'b0;
    endcase
    if (known) begin
      unknown_run = '0;
      return EV_APPLIED;
    end
    // fourth unknown in a row wipes the drive state
    if (unknown_run >= ERR_LIMIT) begin
      unknown_run = '0;
      clear_drive();
      return EV_ERR_CLEAR;
    end
    unknown_run = unknown_run + 2'd1;
    return EV_UNKNOWN;
  endfunction

  // expected result of one accepted transaction, updates the predictor state
  function automatic rdcd_out_t decode_item(rdcd_in_t item);
    rdcd_evt_t ev;
    rdcd_out_t res;
    if (item.func == FUNC_BYTE) begin
      quiet_ms = '0;
      if (item.rx_byte == prev_code) begin
        ev = EV_REPEAT;
      end else begin
        prev_code = item.rx_byte;
        ev = apply_code(item.rx_byte);
      end
    end else begin
      if (quiet_ms != SILENCE_MAX) quiet_ms = quiet_ms + 1'b1;
      if (quiet_ms > {1'b0, timeout_limit}) begin
        quiet_ms = '0;
        ev = apply_code(CH_T);
        ev = EV_TIMEOUT;
      end else begin
        ev = EV_TICK;
      end
    end
    res.control_word  = ctrl_word;
    res.speed_percent = speed_pct;
    res.event_res     = ev;
    return res;
  endfunction

  // prediction on input acceptance, checking on output acceptance
  always @(posedge clk) begin
    item_taken   <= !rst && in_valid && !in_stall;
    result_taken <= !rst && out_valid && !out_stall;
    if (rst) begin
      timeout_limit = TIMEOUT_RESET;
      prev_code     = '0;
      ctrl_word     = '0;
      speed_pct     = '0;
      unknown_run   = '0;
      quiet_ms      = '0;
    end else begin
      if (cfg_wr_en) timeout_limit = cfg_wr_data;
      if (in_valid && !in_stall) begin
        predicted_reports.push_back(decode_item(in_data));
        items_in++;
      end
      if (out_valid && !out_stall) begin
        if (predicted_reports.size() == 0) begin
          $display("%0t: result with nothing expected, actual %h", $time, out_data);
          fail_count++;
        end else begin
          want_report = predicted_reports.pop_front();
          reports_checked++;
          if (want_report.event_res == EV_TIMEOUT) timeout_clears++;
          if (want_report.event_res == EV_ERR_CLEAR) error_clears++;
          if (want_report.event_res == EV_REPEAT) repeats_seen++;
          if (out_data.control_word !== want_report.control_word) begin
            $display("%0t: control_word expected %h actual %h", $time,
                     want_report.control_word, out_data.control_word);
            fail_count++;
          end
          if (out_data.speed_percent !== want_report.speed_percent) begin
            $display("%0t: speed_percent expected %0d actual %0d", $time,
                     want_report.speed_percent, out_data.speed_percent);
            fail_count++;
          end
          if (out_data.event_res !== want_report.event_res) begin
            $display("%0t: event_res expected %0d actual %0d", $time,
                     want_report.event_res, out_data.event_res);
            fail_count++;
          end
        end
      end
    end
  end

  // sender: presents the backlog with a random gap after each transaction
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && item_taken) send_wait = draw_wait(sender_calm);
      if (!in_valid || item_taken) begin
        if (send_wait == 0 && command_backlog.size() > 0) begin
          in_data  <= command_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          if (send_wait > 0) send_wait--;
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stalls for a random count after each result, plus odd idle stalls
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (result_taken) recv_wait = draw_wait(receiver_calm);
      if (recv_wait > 0) begin
        out_stall <= 1'b1;
        recv_wait--;
      end else begin
        out_stall <= !receiver_calm && ($urandom_range(0, 7) == 0);
      end
    end
  end

  task automatic send_byte(logic [7:0] b);
    rdcd_in_t item;
    item.func    = FUNC_BYTE;
    item.rx_byte = b;
    command_backlog.push_back(item);
  endtask

  task automatic send_tick();
    rdcd_in_t item;
    item.func    = FUNC_TICK;
    item.rx_byte = 8'($urandom_range(0, 255));
    command_backlog.push_back(item);
  endtask

  // block until every transaction has gone in and every result has come out
  task automatic wait_drained();
    do @(posedge clk);
    while (command_backlog.size() != 0 || in_valid || predicted_reports.size() != 0);
  endtask

  task automatic write_timeout(logic [15:0] tmo);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= tmo;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  // mostly real command traffic, with repeats, noise, unknown bursts and tick runs
  task automatic fill_random(int unsigned n_items, int unsigned tmo_ms);
    int unsigned made;
    int unsigned pick;
    int unsigned run;
    logic [7:0]  prior;
    made  = 0;
    prior = '0;
    while (made < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        prior = command_set[$urandom_range(0, 29)];
        send_byte(prior);
        made++;
      end else if (pick < 50) begin
        send_byte(prior);
        made++;
      end else if (pick < 60) begin
        prior = 8'($urandom_range(0, 255));
        send_byte(prior);
        made++;
      end else if (pick < 68) begin
        // run of unknown codes long enough to trip the error clear
        repeat (4) begin
          pick = $urandom_range(0, 127);
          if ((8'h80 | 8'(pick)) == prior) pick = pick ^ 1;
          prior = 8'h80 | 8'(pick);
          send_byte(prior);
        end
        made += 4;
      end else begin
        run = $urandom_range(1, (tmo_ms < 30) ? tmo_ms + 2 : 12);
        repeat (run) send_tick();
        made += run;
      end
    end
  endtask

  // stimulus
  initial begin
    command_set = '{CH_T, CH_D, CH_S, CH_F, CH_L, CH_B, CH_R, CH_G, CH_I, CH_H,
                    CH_J, CH_VU, CH_VL, CH_WU, CH_WL, CH_UU, CH_UL, CH_XU, CH_XL,
                    CH_0, CH_1, CH_2, CH_3, CH_4, CH_5, CH_6, CH_7, CH_8, CH_9, CH_Q};
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // directed: zero byte after reset is a repeat, every direction and feature,
    // speed extremes, an unknown run ending in an error clear, both clear codes
    send_byte(8'h00);
    send_byte(CH_F);
    send_byte(CH_F);
    send_byte(CH_G);
    send_byte(CH_I);
    send_byte(CH_H);
    send_byte(CH_J);
    send_byte(CH_L);
    send_byte(CH_B);
    send_byte(CH_R);
    send_byte(CH_S);
    send_byte(CH_VU);
    send_byte(CH_WU);
    send_byte(CH_UU);
    send_byte(CH_XU);
    send_byte(CH_1);
    send_byte(CH_8);
    send_byte(CH_9);
    send_byte(CH_Q);
    send_byte(CH_XL);
    send_byte(CH_VL);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(8'h7F);
    send_byte(CH_T);
    send_tick();
    send_byte(CH_D);

    // zero timeout: every tick clears
    write_timeout(16'd0);
    send_byte(CH_WU);
    send_tick();
    send_tick();
    send_byte(CH_0);

    // random phases over a spread of timeouts
    write_timeout(16'hFFFF);
    sender_calm = 1'b1;
    fill_random(60, 16'hFFFF);
    write_timeout(16'd3);
    sender_calm = 1'b0;
    fill_random(50, 3);
    // sender holds off until the decoder has returned everything
    wait_drained();
    fill_random(50, 3);
    write_timeout(16'd20);
    receiver_calm = 1'b1;
    fill_random(100, 20);
    write_timeout(16'd1);
    receiver_calm = 1'b0;
    fill_random(80, 1);
    write_timeout(16'd0);
    sender_calm   = 1'b1;
    receiver_calm = 1'b1;
    fill_random(50, 0);
    write_timeout(TIMEOUT_RESET);
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
    fill_random(60, TIMEOUT_RESET);
    write_timeout(16'd9);
    fill_random(80, 9);

    wait_drained();
    repeat (10) @(posedge clk);
    $display("covered %0d transactions and %0d checked results over 8 timeout settings",
             items_in, reports_checked);
    $display("seen %0d timeout clears, %0d error clears, %0d repeated codes",
             timeout_clears, error_clears, repeats_seen);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #500000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
